@@ rtl/core/pctt_pkg.sv @@
// Package for the periodic compare tick timer: item types, command codes
// and default sizes. No dependencies; imported by periodic_compare_tick_timer_top.
package pctt_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int COUNT_W          = 64;
	localparam int CMP_W            = 32;
	localparam int FLAG_W           = 4;
	localparam int CHAN_FIELD_W     = 2;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_ACK   = 2'd2,
		FUNC_QUERY = 2'd3
	} func_t;

	typedef struct packed {
		func_t                   func;
		logic [CHAN_FIELD_W-1:0] channel;
		logic [CMP_W-1:0]        period;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count_now;
		logic [FLAG_W-1:0]  match_flags;
		logic [CMP_W-1:0]   ticks_taken;
		logic [COUNT_W-1:0] since_start;
		logic               tick_missed;
	} out_item_t;

endpackage

@@ rtl/core/periodic_compare_tick_timer_top.sv @@
// Top level of the periodic compare tick timer: 64-bit free-running counter,
// compare channels and per-channel periodic bookkeeping. Depends on pctt_pkg.
//
// Usage:
//   The input channel (in_valid / in_stall / in_item) carries one command per
//   item: a counter tick, a start of a channel with its period, an
//   acknowledge of a channel's match, or a query. The output channel
//   (out_valid / out_stall / out_item) returns exactly one result item per
//   command, showing counter, match flags and the addressed channel's
//   bookkeeping after the command.
//   An item is taken at a rising edge with valid high and stall low.
//   An accepted item goes through the input register, then one pass of logic
//   into the result register, from which it appears on out_item.
//   Throughput: one item per cycle while out_stall stays low; the counter
//   and all state update in the same pass that fills the result register.
//   When the receiver stalls, the result register holds; one more item may
//   wait in the input register, after which in_stall rises.
//   Reset (arst_n low) clears the counter, all channel state, match bits and
//   both valid flags at once; in_stall is low out of reset, so items are taken.
//   Channels at or above NUM_CHANNELS ignore start and acknowledge and report
//   zero bookkeeping.
module periodic_compare_tick_timer_top #(
	parameter int NUM_CHANNELS = pctt_pkg::NUM_CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pctt_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output pctt_pkg::out_item_t out_item
);
	import pctt_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// input register
	logic      valid_s1;
	in_item_t  item_s1;

	// result register
	logic      out_valid_q;
	out_item_t out_item_q;

	// timer state
	logic [COUNT_W-1:0]      cnt_q, cnt_inc_q;
	logic [NUM_CHANNELS-1:0] match_q;
	logic [CMP_W-1:0]        cmp_q   [NUM_CHANNELS];
	logic [COUNT_W-1:0]      start_q [NUM_CHANNELS];
	logic [COUNT_W-1:0]      due_q   [NUM_CHANNELS];
	logic [CMP_W-1:0]        ival_q  [NUM_CHANNELS];
	logic [CMP_W-1:0]        tally_q [NUM_CHANNELS];

	// next state
	logic [COUNT_W-1:0]      cnt_n, cnt_inc_n;
	logic [NUM_CHANNELS-1:0] match_n;
	logic [CMP_W-1:0]        cmp_n   [NUM_CHANNELS];
	logic [COUNT_W-1:0]      start_n [NUM_CHANNELS];
	logic [COUNT_W-1:0]      due_n   [NUM_CHANNELS];
	logic [CMP_W-1:0]        ival_n  [NUM_CHANNELS];
	logic [CMP_W-1:0]        tally_n [NUM_CHANNELS];

	logic                           advance, fire, accept, present;
	logic [CH_W-1:0]                sel;
	logic [COUNT_W-1:0]             due_ack, due_start;
	logic [FLAG_W+NUM_CHANNELS-1:0] flags_wide;
	out_item_t                      result;

	// Result register moves on when empty or when the receiver takes it.
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Channel decode: absent channels are steered to entry zero and gated off.
	assign present = (int'(item_s1.channel) < NUM_CHANNELS);
	assign sel     = present ? CH_W'(item_s1.channel) : '0;

	assign due_ack   = due_q[sel] + COUNT_W'(ival_q[sel]);
	assign due_start = cnt_q + COUNT_W'(item_s1.period);

	always_comb begin
		cnt_n     = cnt_q;
		cnt_inc_n = cnt_inc_q;
		match_n   = match_q;
		cmp_n     = cmp_q;
		start_n   = start_q;
		due_n     = due_q;
		ival_n    = ival_q;
		tally_n   = tally_q;
		result    = '0;

		case (item_s1.func)
			FUNC_TICK: begin
				// advance the counter and compare every channel against the new low word
				cnt_n     = cnt_inc_q;
				cnt_inc_n = cnt_inc_q + COUNT_W'(1);
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (cmp_q[i] == cnt_inc_q[CMP_W-1:0]) begin
						match_n[i] = 1'b1;
					end
				end
			end
			FUNC_START: begin
				if (present) begin
					start_n[sel] = cnt_q;
					tally_n[sel] = '0;
					ival_n[sel]  = item_s1.period;
					due_n[sel]   = due_start;
					cmp_n[sel]   = due_start[CMP_W-1:0];
				end
			end
			FUNC_ACK: begin
				if (present) begin
					match_n[sel]       = 1'b0;
					tally_n[sel]       = tally_q[sel] + CMP_W'(1);
					due_n[sel]         = due_ack;
					cmp_n[sel]         = due_ack[CMP_W-1:0];
					result.tick_missed = (due_ack <= cnt_q);
				end
			end
			default: begin
				// query: no state change
			end
		endcase

		flags_wide         = (FLAG_W + NUM_CHANNELS)'(match_n);
		result.count_now   = cnt_n;
		result.match_flags = flags_wide[FLAG_W-1:0];
		result.ticks_taken = present ? tally_n[sel] : '0;
		result.since_start = present ? (cnt_n - start_n[sel]) : '0;
	end

	// Input register: hold while the result side is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q <= result;
		end
	end

	// Timer state, committed once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			cnt_inc_q <= COUNT_W'(1);
			match_q   <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				cmp_q[i]   <= '0;
				start_q[i] <= '0;
				due_q[i]   <= '0;
				ival_q[i]  <= '0;
				tally_q[i] <= '0;
			end
		end else if (fire) begin
			cnt_q     <= cnt_n;
			cnt_inc_q <= cnt_inc_n;
			match_q   <= match_n;
			cmp_q     <= cmp_n;
			start_q   <= start_n;
			due_q     <= due_n;
			ival_q    <= ival_n;
			tally_q   <= tally_n;
		end
	end

endmodule
